// File: hdl/dsst_pkg.sv
// Shared types, codes and sizes for the descending score sorted table.
`timescale 1ns / 1ps
`default_nettype none

package dsst_pkg;

  // Default number of table slots
  localparam int TABLE_DEPTH_DEF = 16;

  // A dump reports at most this many entries
  localparam int MAX_DUMP = 16;

  // Field widths fixed by the interface
  localparam int FUNC_W  = 2;
  localparam int ID_W    = 16;
  localparam int TAG_W   = 32;
  localparam int SCORE_W = 14;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_INSERTED = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_DUMP     = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_CLEARED  = 3'd4
  } status_t;

  // One stored record
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DMP_RD,
    S_DMP_EMIT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// File: hdl/dsst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dsst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; read data holds until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/descending_score_sorted_table.sv
// Top level of the descending score sorted table with its insert and dump sequencer.
//
// Usage: items enter on the in_valid/in_ready channel with func, rec_id,
// name_tag and score_in; results leave on out_valid/out_ready with status,
// position, out_id, out_name_tag, out_score and last.
// func insert places the record behind every stored record of equal or
// higher score and reports its rank; a full table reports a reject.
// func dump returns one item per stored entry in rank order (at most 16),
// last set on the final one; an empty table returns one empty status.
// func clear empties the table and returns one cleared status.
// The code left over gives no result.
// Throughput: one item at a time; in_ready is high only when idle.
// Insert: with k stored entries ranking below the new record, each moved
// entry is read (S_INS_RD), then written one slot lower (S_INS_CMP), walked
// from the bottom of the one-read, one-write table RAM; the record is then
// written in S_INS_CMP, or in S_INS_RD at the top rank. Dump: each entry is
// a RAM read (S_DMP_RD), then an output load (S_DMP_EMIT). Clear, reject
// and empty dump: result 1 cycle after acceptance. Each item returns the
// sequencer to idle before the next accept. While out_ready is low, the
// output register holds its item and the sequencer waits before its next
// load. Reset empties the table at once and drops any pending output item.
`timescale 1ns / 1ps
`default_nettype none

module descending_score_sorted_table #(
  parameter int TABLE_DEPTH = dsst_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dsst_pkg::FUNC_W-1:0]  func,
  input  wire logic [dsst_pkg::ID_W-1:0]    rec_id,
  input  wire logic [dsst_pkg::TAG_W-1:0]   name_tag,
  input  wire logic [dsst_pkg::SCORE_W-1:0] score_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [dsst_pkg::STAT_W-1:0]  status,
  output logic      [dsst_pkg::POS_W-1:0]   position,
  output logic      [dsst_pkg::ID_W-1:0]    out_id,
  output logic      [dsst_pkg::TAG_W-1:0]   out_name_tag,
  output logic      [dsst_pkg::SCORE_W-1:0] out_score,
  output logic                              last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(dsst_pkg::entry_t);

  dsst_pkg::state_t  state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  dsst_pkg::entry_t  new_entry, new_entry_next;
  dsst_pkg::status_t resp_status, resp_status_next;
  logic [dsst_pkg::POS_W-1:0] resp_pos, resp_pos_next;

  // Output register next values
  logic                         load_out;
  dsst_pkg::status_t            status_next;
  logic [dsst_pkg::POS_W-1:0]   position_next;
  dsst_pkg::entry_t             out_entry_next;
  logic                         last_next;

  // Table RAM ports
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  dsst_pkg::entry_t wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    rd_raw;
  dsst_pkg::entry_t rd_entry;

  logic          out_free;
  logic [CW-1:0] dump_n;
  logic          dump_last;

  dsst_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = dsst_pkg::entry_t'(rd_raw);
  assign in_ready = (state == dsst_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Limit the dump length
  assign dump_n = (32'(count) > dsst_pkg::MAX_DUMP) ? CW'(dsst_pkg::MAX_DUMP) : count;
  assign dump_last = ((idx + 1'b1) == dump_n);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsst_pkg::S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_entry   <= new_entry_next;
    resp_status <= resp_status_next;
    resp_pos    <= resp_pos_next;
    if (load_out) begin
      status       <= status_next;
      position     <= position_next;
      out_id       <= out_entry_next.id;
      out_name_tag <= out_entry_next.tag;
      out_score    <= out_entry_next.score;
      last         <= last_next;
    end
  end

  // Sequencer: next state, RAM access and output load
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    new_entry_next   = new_entry;
    resp_status_next = resp_status;
    resp_pos_next    = resp_pos;
    load_out         = 1'b0;
    status_next      = resp_status;
    position_next    = resp_pos;
    out_entry_next   = '0;
    last_next        = 1'b1;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = new_entry;
    rd_en            = 1'b0;
    rd_addr          = '0;

    case (state)
      dsst_pkg::S_IDLE: begin
        if (in_valid) begin
          new_entry_next = '{id: rec_id, tag: name_tag, score: score_in};
          case (func)
            dsst_pkg::FUNC_INSERT: begin
              if (count == CW'(TABLE_DEPTH)) begin
                resp_status_next = dsst_pkg::STATUS_FULL;
                resp_pos_next    = '0;
                state_next       = dsst_pkg::S_RESP;
              end else begin
                idx_next   = count;
                state_next = dsst_pkg::S_INS_RD;
              end
            end
            dsst_pkg::FUNC_DUMP: begin
              if (count == '0) begin
                resp_status_next = dsst_pkg::STATUS_EMPTY;
                resp_pos_next    = '0;
                state_next       = dsst_pkg::S_RESP;
              end else begin
                idx_next   = '0;
                state_next = dsst_pkg::S_DMP_RD;
              end
            end
            dsst_pkg::FUNC_CLEAR: begin
              count_next       = '0;
              resp_status_next = dsst_pkg::STATUS_CLEARED;
              resp_pos_next    = '0;
              state_next       = dsst_pkg::S_RESP;
            end
            default: begin
              state_next = dsst_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Place at the top, or fetch the entry just above the free slot
      dsst_pkg::S_INS_RD: begin
        if (idx == '0) begin
          wr_en            = 1'b1;
          wr_addr          = '0;
          count_next       = count + 1'b1;
          resp_status_next = dsst_pkg::STATUS_INSERTED;
          resp_pos_next    = '0;
          state_next       = dsst_pkg::S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(idx - 1'b1);
          state_next = dsst_pkg::S_INS_CMP;
        end
      end

      // Stop behind an equal or higher score, else move the entry down
      dsst_pkg::S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx);
        if (rd_entry.score >= new_entry.score) begin
          count_next       = count + 1'b1;
          resp_status_next = dsst_pkg::STATUS_INSERTED;
          resp_pos_next    = dsst_pkg::POS_W'(idx);
          state_next       = dsst_pkg::S_RESP;
        end else begin
          wr_data    = rd_entry;
          idx_next   = idx - 1'b1;
          state_next = dsst_pkg::S_INS_RD;
        end
      end

      dsst_pkg::S_DMP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(idx);
        state_next = dsst_pkg::S_DMP_EMIT;
      end

      // Emit one dump item when the output register is free
      dsst_pkg::S_DMP_EMIT: begin
        if (out_free) begin
          load_out       = 1'b1;
          status_next    = dsst_pkg::STATUS_DUMP;
          position_next  = dsst_pkg::POS_W'(idx);
          out_entry_next = rd_entry;
          last_next      = dump_last;
          idx_next       = idx + 1'b1;
          state_next     = dump_last ? dsst_pkg::S_IDLE : dsst_pkg::S_DMP_RD;
        end
      end

      // Emit the single result of insert, reject, empty or clear
      dsst_pkg::S_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = dsst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = dsst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/dsst_checker.sv
// Port-level checker for the descending score sorted table and its bind.
`timescale 1ns / 1ps
`default_nettype none

module dsst_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [dsst_pkg::FUNC_W-1:0]  func,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [dsst_pkg::STAT_W-1:0]  status,
  input wire logic [dsst_pkg::POS_W-1:0]   position,
  input wire logic [dsst_pkg::ID_W-1:0]    out_id,
  input wire logic [dsst_pkg::TAG_W-1:0]   out_name_tag,
  input wire logic [dsst_pkg::SCORE_W-1:0] out_score,
  input wire logic                         last
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(out_id) && $stable(out_name_tag) && $stable(out_score) && $stable(last))
    else $error("stalled result item changed");

  // Only dump items carry entry data
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dsst_pkg::STATUS_DUMP |->
      out_id == '0 && out_name_tag == '0 && out_score == '0)
    else $error("non-dump result carries entry data");

  // Single-result operations always end their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dsst_pkg::STATUS_DUMP |-> last
      && (status == dsst_pkg::STATUS_INSERTED || position == '0))
    else $error("single result without last or with stray position");

  // An operation with results keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == dsst_pkg::FUNC_INSERT || func == dsst_pkg::FUNC_DUMP
      || func == dsst_pkg::FUNC_CLEAR) |=> !in_ready)
    else $error("input accepted while an operation is in progress");

endmodule

bind descending_score_sorted_table dsst_checker u_dsst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .func         (func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .position     (position),
  .out_id       (out_id),
  .out_name_tag (out_name_tag),
  .out_score    (out_score),
  .last         (last)
);

`default_nettype wire
